@@ rtl/smf_pkg.sv @@
package smf_pkg;

	// Sizes of the pattern store, the text window and the line counter, and the match limit ceiling
	localparam int PATTERN_MAX = 32;
	localparam int LINE_MAX = 65536;
	localparam int SEARCH_CEILING = 256000;

	// Field widths
	localparam int CHAR_W = 21;
	localparam int PIDX_W = $clog2(PATTERN_MAX);
	localparam int LINE_W = 24;
	localparam int COL_W = 16;
	localparam int COUNT_W = 18;
	localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
	localparam int CIL_W = $clog2(LINE_MAX + 1);
	localparam int SHIFT_W = $clog2(PATTERN_MAX);

	// Stream word layout
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 64;
	localparam int PADDR_W = 4;

	// Request kinds carried in s_tuser
	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_TEXT   = 2'd1,
		REQ_START  = 2'd2,
		REQ_CANCEL = 2'd3
	} req_t;

	// Register indexes (paddr[3:2])
	typedef enum logic [1:0] {
		REG_MATCH_LIMIT = 2'd0,
		REG_CASE_INSENS = 2'd1,
		REG_PATTERN_LEN = 2'd2
	} reg_idx_t;

	typedef logic [CHAR_W-1:0] char_t;

endpackage

@@ rtl/substring_match_finder.sv @@
// Channel   Direction  Handshake         Payload
// s_*       in         s_tvalid/s_tready req in tuser, char/index/line in tdata, tlast ends line
// m_*       out        m_tvalid/m_tready line/column/total in tdata, limit_hit in tuser
// apb       in         psel & penable    match_limit, case_insensitive, pattern_length
//
// One word per cycle sustained while the result register is not stalled: a word is registered at input, then the window
// shift, the parallel pattern compare and the count update run combinationally into
// the result register. Only a matching text word gives a result, through the input and result registers.
// Reset clears the window, the line counter, the match count and the stop flag.
// A stalled result holds the pipeline; one word still waits in the input stage.
module substring_match_finder (
	input  logic                             clk,
	input  logic                             arst_n,
	// s_tdata: char_code[20:0], pattern_index[25:21], line_number[49:26], zero fill
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [smf_pkg::S_TDATA_W-1:0]    s_tdata,
	// s_tuser: req_type[1:0]
	input  logic [1:0]                       s_tuser,
	input  logic                             s_tlast,
	// m_tdata: match_line[23:0], match_column[39:24], match_total[57:40], zero fill
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [smf_pkg::M_TDATA_W-1:0]    m_tdata,
	// m_tuser: limit_hit[0]
	output logic                             m_tuser,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [smf_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int PM = smf_pkg::PATTERN_MAX;
	localparam int CW = smf_pkg::CHAR_W;
	localparam int WIN_BITS = PM * CW;
	localparam int SH_PROD_W = $clog2(WIN_BITS);
	localparam int SHIFT_W_LOCAL = smf_pkg::SHIFT_W;

	// Configuration registers
	logic [smf_pkg::COUNT_W-1:0] match_limit_q;
	logic                        case_insens_q;
	logic [smf_pkg::PLEN_W-1:0]  pattern_len_q;

	// Input stage
	logic                        valid_s1;
	smf_pkg::req_t               req_s1;
	smf_pkg::char_t              char_s1;
	logic [smf_pkg::PIDX_W-1:0]  pidx_s1;
	logic [smf_pkg::LINE_W-1:0]  line_s1;
	logic                        last_s1;

	// Search state
	smf_pkg::char_t              pattern_q [PM];
	smf_pkg::char_t              win_q [PM];
	logic [smf_pkg::CIL_W-1:0]   cil_q;
	logic [smf_pkg::COUNT_W-1:0] found_q;
	logic                        stopped_q;

	// Result register
	logic                        out_valid_q;
	logic [smf_pkg::LINE_W-1:0]  out_line_q;
	logic [smf_pkg::COL_W-1:0]   out_col_q;
	logic [smf_pkg::COUNT_W-1:0] out_total_q;
	logic                        out_limit_q;

	logic advance;
	logic take_s1;
	logic wr_en;

	// Compare path
	smf_pkg::char_t              win_nx [PM];
	logic [WIN_BITS-1:0]         win_flat;
	logic [WIN_BITS-1:0]         win_algn;
	logic [SHIFT_W_LOCAL-1:0]    shamt;
	logic [PM-1:0]               eq_vec;
	logic                        win_hit;
	logic [smf_pkg::CIL_W:0]     pos_p1;
	logic                        is_match;
	logic [smf_pkg::COUNT_W-1:0] found_nx;

	function automatic smf_pkg::char_t fold(input smf_pkg::char_t c, input logic ci);
		smf_pkg::char_t r;
		r = c;
		if (ci && c >= smf_pkg::char_t'(8'h41) && c <= smf_pkg::char_t'(8'h5A)) begin
			r = c + smf_pkg::char_t'(8'h20);
		end
		return r;
	endfunction

	// Handshake: input stage moves on whenever the result register can take a word
	assign advance  = !out_valid_q || m_tready;
	assign take_s1  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_total_q, out_col_q, out_line_q};
	assign m_tuser  = out_limit_q;

	// APB register file
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_limit_q <= smf_pkg::COUNT_W'(smf_pkg::SEARCH_CEILING);
			case_insens_q <= 1'b0;
			pattern_len_q <= smf_pkg::PLEN_W'(1);
		end else if (wr_en) begin
			unique case (paddr[3:2])
				smf_pkg::REG_MATCH_LIMIT: begin
					if (pwdata[smf_pkg::COUNT_W-1:0] == '0)
						match_limit_q <= smf_pkg::COUNT_W'(1);
					else if (pwdata[smf_pkg::COUNT_W-1:0] >
					         smf_pkg::COUNT_W'(smf_pkg::SEARCH_CEILING))
						match_limit_q <= smf_pkg::COUNT_W'(smf_pkg::SEARCH_CEILING);
					else
						match_limit_q <= pwdata[smf_pkg::COUNT_W-1:0];
				end
				smf_pkg::REG_CASE_INSENS: begin
					case_insens_q <= pwdata[0];
				end
				smf_pkg::REG_PATTERN_LEN: begin
					if (pwdata[5:0] == 6'd0)
						pattern_len_q <= smf_pkg::PLEN_W'(1);
					else if ({26'd0, pwdata[5:0]} > 32'(PM))
						pattern_len_q <= smf_pkg::PLEN_W'(PM);
					else
						pattern_len_q <= smf_pkg::PLEN_W'(pwdata[5:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[3:2])
			smf_pkg::REG_MATCH_LIMIT: prdata = 32'(match_limit_q);
			smf_pkg::REG_CASE_INSENS: prdata = 32'(case_insens_q);
			smf_pkg::REG_PATTERN_LEN: prdata = 32'(pattern_len_q);
			default:                  prdata = '0;
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= smf_pkg::req_t'(s_tuser);
			char_s1 <= s_tdata[20:0];
			pidx_s1 <= s_tdata[25:21];
			line_s1 <= s_tdata[49:26];
			last_s1 <= s_tlast;
		end
	end

	// Window with the new character at the top; oldest at index 0
	always_comb begin
		for (int m = 0; m < PM - 1; m++) begin
			win_nx[m] = win_q[m+1];
		end
		win_nx[PM-1] = char_s1;
		for (int m = 0; m < PM; m++) begin
			win_flat[m*CW +: CW] = win_nx[m];
		end
	end

	// Align the last pattern_length characters to element 0, then compare in parallel
	assign shamt    = SHIFT_W_LOCAL'(PM - int'(pattern_len_q));
	assign win_algn = win_flat >> (SH_PROD_W'(shamt) * SH_PROD_W'(CW));

	always_comb begin
		for (int j = 0; j < PM; j++) begin
			eq_vec[j] = (j >= int'(pattern_len_q)) ||
			            (fold(pattern_q[j], case_insens_q) ==
			             fold(win_algn[j*CW +: CW], case_insens_q));
		end
	end

	assign win_hit  = &eq_vec;
	assign pos_p1   = {1'b0, cil_q} + 1'b1;
	assign is_match = !stopped_q && (cil_q < smf_pkg::CIL_W'(smf_pkg::LINE_MAX)) &&
	                  (pos_p1 >= (smf_pkg::CIL_W+1)'(pattern_len_q)) && win_hit;
	assign found_nx = found_q + 1'b1;

	// Pattern store, no reset
	always_ff @(posedge clk) begin
		if (take_s1 && req_s1 == smf_pkg::REQ_LOAD) begin
			pattern_q[pidx_s1] <= char_s1;
		end
	end

	// Search state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < PM; m++) win_q[m] <= '0;
			cil_q     <= '0;
			found_q   <= '0;
			stopped_q <= 1'b0;
		end else if (take_s1) begin
			case (req_s1)
				smf_pkg::REQ_START: begin
					for (int m = 0; m < PM; m++) win_q[m] <= '0;
					cil_q     <= '0;
					found_q   <= '0;
					stopped_q <= 1'b0;
				end
				smf_pkg::REQ_CANCEL: begin
					stopped_q <= 1'b1;
				end
				smf_pkg::REQ_TEXT: begin
					win_q <= win_nx;
					if (last_s1)
						cil_q <= '0;
					else if (cil_q < smf_pkg::CIL_W'(smf_pkg::LINE_MAX))
						cil_q <= smf_pkg::CIL_W'(pos_p1);
					if (is_match) begin
						found_q <= found_nx;
						if (found_nx >= match_limit_q)
							stopped_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= take_s1 && req_s1 == smf_pkg::REQ_TEXT && is_match;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && req_s1 == smf_pkg::REQ_TEXT && is_match) begin
			out_line_q  <= line_s1;
			out_col_q   <= smf_pkg::COL_W'(pos_p1 - (smf_pkg::CIL_W+1)'(pattern_len_q));
			out_total_q <= found_nx;
			out_limit_q <= found_nx >= match_limit_q;
		end
	end

	// Checks
	a_total_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_total_q == found_q)
		else $error("pending result total differs from match count");

	a_limit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_limit_q |-> stopped_q)
		else $error("limit reached but search not stopped");

	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cil_q <= smf_pkg::CIL_W'(smf_pkg::LINE_MAX))
		else $error("line counter beyond bound");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_valid_q && !m_tready)
		else $error("input stalled without a blocked result");

endmodule
